// ----- rtl/sfrc_pkg.sv -----
package sfrc_pkg;

  // Result event codes.
  localparam logic [2:0] EV_HUNT     = 3'd0;
  localparam logic [2:0] EV_HEADER   = 3'd1;
  localparam logic [2:0] EV_STORED   = 3'd2;
  localparam logic [2:0] EV_COMPLETE = 3'd3;
  localparam logic [2:0] EV_OVERFLOW = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_HEADER_FIRST   = 2'd0;
  localparam logic [1:0] CFG_HEADER_SECOND  = 2'd1;
  localparam logic [1:0] CFG_TRAILER_FIRST  = 2'd2;
  localparam logic [1:0] CFG_TRAILER_SECOND = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [7:0] HEADER_FIRST_RST   = 8'hAA;
  localparam logic [7:0] HEADER_SECOND_RST  = 8'h55;
  localparam logic [7:0] TRAILER_FIRST_RST  = 8'h0D;
  localparam logic [7:0] TRAILER_SECOND_RST = 8'h0A;

  typedef struct packed {
    logic [7:0] header_first;
    logic [7:0] header_second;
    logic [7:0] trailer_first;
    logic [7:0] trailer_second;
  } cfg_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] stored_byte;
    logic [5:0] stored_index;
    logic [6:0] frame_length;
    logic       checksum_ok;
  } res_t;

endpackage

// ----- rtl/sfrc_parser.sv -----
module sfrc_parser import sfrc_pkg::*; #(
  parameter int FRAME_CAPACITY = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  cfg_t       cfg_i,
  output res_t       res_o
);

  localparam int CW = $clog2(FRAME_CAPACITY + 1);

  logic          in_frame_q, in_frame_d;
  logic [15:0]   header_win_q, header_win_d;
  logic [15:0]   trailer_win_q, trailer_win_d;
  logic [CW-1:0] count_q, count_d;
  logic [7:0]    sum_q, sum_d;
  logic [15:0]   last_two_q, last_two_d;
  logic [CW-1:0] count_inc;
  logic          two_stored;

  assign count_inc  = count_q + CW'(1);
  assign two_stored = (count_q >= CW'(2));

  always_comb begin
    in_frame_d    = in_frame_q;
    header_win_d  = header_win_q;
    trailer_win_d = trailer_win_q;
    count_d       = count_q;
    sum_d         = sum_q;
    last_two_d    = last_two_q;
    res_o         = '0;
    res_o.event_res = EV_HUNT;

    if (in_frame_q) begin
      trailer_win_d = {trailer_win_q[7:0], byte_i};
      if (trailer_win_q[7:0] == cfg_i.trailer_first && byte_i == cfg_i.trailer_second) begin
        res_o.event_res    = EV_COMPLETE;
        res_o.frame_length = 7'(count_q);
        res_o.checksum_ok  = two_stored && (sum_q == last_two_q[15:8]);
        count_d            = '0;
        in_frame_d         = 1'b0;
      end else begin
        if (two_stored) begin
          sum_d = sum_q + last_two_q[15:8];
        end
        last_two_d         = {last_two_q[7:0], byte_i};
        res_o.stored_byte  = byte_i;
        res_o.stored_index = 6'(count_q);
        if (count_inc >= CW'(FRAME_CAPACITY)) begin
          res_o.event_res = EV_OVERFLOW;
          count_d         = '0;
          in_frame_d      = 1'b0;
        end else begin
          res_o.event_res = EV_STORED;
          count_d         = count_inc;
        end
      end
    end else begin
      header_win_d = {header_win_q[7:0], byte_i};
      if (header_win_q[7:0] == cfg_i.header_first && byte_i == cfg_i.header_second) begin
        res_o.event_res = EV_HEADER;
        in_frame_d      = 1'b1;
        count_d         = '0;
        sum_d           = '0;
        last_two_d      = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q    <= 1'b0;
      header_win_q  <= '0;
      trailer_win_q <= '0;
      count_q       <= '0;
      sum_q         <= '0;
      last_two_q    <= '0;
    end else if (step_i) begin
      in_frame_q    <= in_frame_d;
      header_win_q  <= header_win_d;
      trailer_win_q <= trailer_win_d;
      count_q       <= count_d;
      sum_q         <= sum_d;
      last_two_q    <= last_two_d;
    end
  end

endmodule

// ----- rtl/serial_frame_receiver_checksum.sv -----
// Byte-serial frame receiver. Each rx transaction carries one received byte and
// yields exactly one result transaction. While hunting, the block looks for the
// two configured header bytes in a row; inside a frame, every byte is reported
// with its index until the two configured trailer bytes arrive (frame complete,
// with the checksum verdict: the 8-bit sum of all stored bytes except the last
// two must equal the second-to-last stored byte) or until FRAME_CAPACITY bytes
// have been stored (overflow abort). Throughput is one byte per clock cycle while
// the result channel does not stall. A byte accepted on the rx channel lands in
// an input register; when it moves on, the per-byte state update runs and loads
// the result register, from which the result is offered. The result register
// is stalled only by the result channel. While a result waits, the input
// register can still take one more byte; after that the rx channel stalls until
// the waiting result is taken.
// Configuration registers are written through a plain write port and should
// only be changed while no byte is in flight.
module serial_frame_receiver_checksum import sfrc_pkg::*; #(
  parameter int FRAME_CAPACITY = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,

  // Configuration write port.
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_wdata_i,

  // Received byte channel.
  input  logic       rx_valid_i,
  output logic       rx_stall_o,
  input  logic [7:0] rx_byte_i,

  // Result channel.
  output logic       res_valid_o,
  input  logic       res_stall_i,
  output logic [2:0] event_res_o,
  output logic [7:0] stored_byte_o,
  output logic [5:0] stored_index_o,
  output logic [6:0] frame_length_o,
  output logic       checksum_ok_o
);

  cfg_t       cfg_q;
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  res_t       out_res_q;
  res_t       res_next;
  logic       advance;
  logic       rx_accept;

  // Configuration registers. Writes take effect at the next edge.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_first   <= HEADER_FIRST_RST;
      cfg_q.header_second  <= HEADER_SECOND_RST;
      cfg_q.trailer_first  <= TRAILER_FIRST_RST;
      cfg_q.trailer_second <= TRAILER_SECOND_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_HEADER_FIRST:   cfg_q.header_first   <= cfg_wdata_i;
        CFG_HEADER_SECOND:  cfg_q.header_second  <= cfg_wdata_i;
        CFG_TRAILER_FIRST:  cfg_q.trailer_first  <= cfg_wdata_i;
        CFG_TRAILER_SECOND: cfg_q.trailer_second <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The byte in the input register moves on whenever the result register is
  // empty or is being drained in this cycle.
  assign advance    = in_valid_q && (!out_valid_q || !res_stall_i);
  assign rx_stall_o = in_valid_q && !advance;
  assign rx_accept  = rx_valid_i && !rx_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_accept) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // Frame state and per-byte decision logic.
  sfrc_parser #(
    .FRAME_CAPACITY(FRAME_CAPACITY)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte_q),
    .cfg_i  (cfg_q),
    .res_o  (res_next)
  );

  // Result register. It holds while the result transaction is stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!res_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res_next;
    end
  end

  assign res_valid_o    = out_valid_q;
  assign event_res_o    = out_res_q.event_res;
  assign stored_byte_o  = out_res_q.stored_byte;
  assign stored_index_o = out_res_q.stored_index;
  assign frame_length_o = out_res_q.frame_length;
  assign checksum_ok_o  = out_res_q.checksum_ok;

endmodule

// ----- rtl/sfrc_checker.sv -----
module sfrc_checker import sfrc_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       res_valid_o,
  input logic       res_stall_i,
  input logic [2:0] event_res_o,
  input logic [7:0] stored_byte_o,
  input logic [5:0] stored_index_o,
  input logic [6:0] frame_length_o,
  input logic       checksum_ok_o
);

  // A stalled result stays and keeps its payload.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_stall_i |=> res_valid_o && $stable(event_res_o) &&
      $stable(stored_byte_o) && $stable(stored_index_o) &&
      $stable(frame_length_o) && $stable(checksum_ok_o))
    else $error("stalled result changed");

  // Length and checksum verdict appear only with a completed frame.
  a_complete_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && event_res_o != EV_COMPLETE |-> frame_length_o == 7'd0 &&
      !checksum_ok_o)
    else $error("frame length or checksum outside frame completion");

  // Byte and index appear only with a stored byte or an overflow.
  a_byte_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (event_res_o == EV_HUNT || event_res_o == EV_HEADER ||
      event_res_o == EV_COMPLETE) |-> stored_byte_o == 8'd0 && stored_index_o == 6'd0)
    else $error("stored byte reported outside a stored event");

  // Consecutive stored bytes within one frame count up by one.
  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_stall_i && event_res_o == EV_STORED ##1
      res_valid_o && (event_res_o == EV_STORED || event_res_o == EV_OVERFLOW)
      |-> stored_index_o == $past(stored_index_o) + 6'd1 ||
          $past(stored_index_o) == 6'd63)
    else $error("stored index did not advance by one");

endmodule

bind serial_frame_receiver_checksum sfrc_checker u_sfrc_checker (.*);
